/* rtl/rfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared widths, operation and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package rfa_pkg;

   localparam int WIDTH = 32;
   localparam int PW    = 2 * WIDTH;
   localparam int CW    = 6;

   localparam logic [2:0] FN_ADD  = 3'd0;
   localparam logic [2:0] FN_SUB  = 3'd1;
   localparam logic [2:0] FN_MUL  = 3'd2;
   localparam logic [2:0] FN_DIV  = 3'd3;
   localparam logic [2:0] FN_EQ   = 3'd4;
   localparam logic [2:0] FN_GT   = 3'd5;
   localparam logic [2:0] FN_LT   = 3'd6;
   localparam logic [2:0] FN_NONE = 3'd7;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZDEN = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   localparam logic [1:0] MSEL_X = 2'd0;
   localparam logic [1:0] MSEL_Y = 2'd1;
   localparam logic [1:0] MSEL_D = 2'd2;

   localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);

   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_MUL,
      CMD_COMBINE,
      CMD_GCD,
      CMD_DIV_INIT,
      CMD_DIV,
      CMD_PUT
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MUL,
      S_COMBINE,
      S_GCD,
      S_DIV_INIT,
      S_DIV,
      S_PUT
   } state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] mul_sel;
   } ctrl_type;

   typedef struct packed {
      logic skip;       // unused code or zero denominator
      logic early_out;  // comparison or zero numerator
      logic gcd_done;
   } stat_type;

endpackage

/* rtl/rational_fraction_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu
// Exact add, sub, mul, div and compare of two signed fractions, with the
// result reduced by the gcd and the denominator kept positive.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       req_func, req_a_num, req_a_den, req_b_num, req_b_den
//  response  rsp_valid strobe   rsp_res_num, rsp_res_den, rsp_cmp_true, rsp_status
//
//  unused code or zero denominator skips straight to the result; a comparison or
//  zero numerator leaves after the cross products. reduction runs the binary gcd
//  loop and then the shared 64-step restoring divide of numerator and denominator.
//  busy drops as the strobe rises; a new transaction may start that cycle.
//  synchronous reset returns the sequencer to idle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module rational_fraction_alu import rfa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [2:0]              req_func,
   input  logic signed [WIDTH-1:0] req_a_num,
   input  logic signed [WIDTH-1:0] req_a_den,
   input  logic signed [WIDTH-1:0] req_b_num,
   input  logic signed [WIDTH-1:0] req_b_den,
   output logic                    rsp_valid,
   output logic signed [WIDTH-1:0] rsp_res_num,
   output logic [WIDTH-2:0]        rsp_res_den,
   output logic                    rsp_cmp_true,
   output logic [1:0]              rsp_status
);

   ctrl_type ctrl;
   stat_type stat;

   rfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .ctrl      (ctrl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   rfa_datapath u_dp (
      .clock        (clock),
      .ctrl         (ctrl),
      .req_func     (req_func),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .stat         (stat),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_cmp_true (rsp_cmp_true),
      .rsp_status   (rsp_status)
   );

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted transaction did not raise busy");

   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result strobe while busy");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_res_num == '0 && rsp_res_den == '0)
      else $error("error result carries a fraction");

endmodule

/* rtl/rfa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_ctrl
// Sequencer: multiplies, combine, binary gcd loop, dual restoring divide.
// ----------------------------------------------------------------------------
module rfa_ctrl import rfa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output ctrl_type ctrl,
   output logic     busy,
   output logic     rsp_valid
);

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          valid_ff, valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      valid_in     = 1'b0;
      ctrl.cmd     = CMD_IDLE;
      ctrl.mul_sel = cnt_ff[1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.cmd = CMD_LOAD;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cnt_in = '0;
            if (stat.skip) state_in = S_PUT;
            else state_in = S_MUL;
         end
         S_MUL: begin
            ctrl.cmd = CMD_MUL;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff[1:0] == MSEL_D) state_in = S_COMBINE;
         end
         S_COMBINE: begin
            ctrl.cmd = CMD_COMBINE;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (stat.early_out) state_in = S_PUT;
            else if (stat.gcd_done) state_in = S_DIV_INIT;
            else ctrl.cmd = CMD_GCD;
         end
         S_DIV_INIT: begin
            ctrl.cmd = CMD_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            ctrl.cmd = CMD_DIV;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = S_PUT;
         end
         S_PUT: begin
            ctrl.cmd = CMD_PUT;
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

/* rtl/rfa_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_datapath
// Operand registers, shared multiplier, sign-magnitude add/compare, gcd and
// divide registers, result registers.
// ----------------------------------------------------------------------------
module rfa_datapath import rfa_pkg::*; (
   input  logic                    clock,
   input  ctrl_type                ctrl,
   input  logic [2:0]              req_func,
   input  logic signed [WIDTH-1:0] req_a_num,
   input  logic signed [WIDTH-1:0] req_a_den,
   input  logic signed [WIDTH-1:0] req_b_num,
   input  logic signed [WIDTH-1:0] req_b_den,
   output stat_type                stat,
   output logic signed [WIDTH-1:0] rsp_res_num,
   output logic [WIDTH-2:0]        rsp_res_den,
   output logic                    rsp_cmp_true,
   output logic [1:0]              rsp_status
);

   localparam logic [PW-1:0] LIM = PW'(1) << (WIDTH - 1);

   function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
      return v[WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   logic [2:0]       func_ff;
   logic             unused_ff, zden_ff, sa_ff, sb_ff;
   logic [WIDTH-1:0] am_ff, adm_ff, bm_ff, bdm_ff;
   logic [PW-1:0]    x_ff, y_ff, d_ff;
   logic             neg_ff, cmp_ff;
   logic [PW-1:0]    nm_ff, dm_ff, u_ff, v_ff, g_ff, rn_ff, rd_ff;
   logic [CW:0]      k_ff;
   logic signed [WIDTH-1:0] num_out_ff;
   logic [WIDTH-2:0] den_out_ff;
   logic             cmpo_ff;
   logic [1:0]       st_ff;

   logic             is_mul, is_div, is_cmp, is_sub;
   logic [WIDTH-1:0] mop_a, mop_b;
   logic [PW-1:0]    prod;
   logic             sy;
   logic [PW-1:0]    sum_mag;
   logic             sum_neg, c_eq, c_gt, c_res;
   logic [PW:0]      rn_t, rd_t;
   logic             ovf;

   assign is_mul = (func_ff == FN_MUL);
   assign is_div = (func_ff == FN_DIV);
   assign is_sub = (func_ff == FN_SUB);
   assign is_cmp = (func_ff == FN_EQ) || (func_ff == FN_GT) || (func_ff == FN_LT);

   always_comb begin
      unique case (ctrl.mul_sel)
         MSEL_X:  begin mop_a = am_ff;  mop_b = is_mul ? bm_ff : bdm_ff; end
         MSEL_Y:  begin mop_a = adm_ff; mop_b = is_mul ? bdm_ff : bm_ff; end
         default: begin mop_a = adm_ff; mop_b = bdm_ff; end
      endcase
   end
   assign prod = PW'(mop_a) * PW'(mop_b);

   // signed-magnitude sum of the two cross products
   always_comb begin
      sy = is_sub ? (sb_ff ^ (y_ff != '0)) : sb_ff;
      if (sa_ff == sy) begin
         sum_mag = x_ff + y_ff;
         sum_neg = sa_ff;
      end else if (x_ff >= y_ff) begin
         sum_mag = x_ff - y_ff;
         sum_neg = sa_ff;
      end else begin
         sum_mag = y_ff - x_ff;
         sum_neg = sy;
      end
      c_eq = (sa_ff == sb_ff) && (x_ff == y_ff);
      if (sa_ff != sb_ff) c_gt = !sa_ff;
      else if (sa_ff) c_gt = (x_ff < y_ff);
      else c_gt = (x_ff > y_ff);
      unique case (func_ff)
         FN_EQ:   c_res = c_eq;
         FN_GT:   c_res = c_gt;
         FN_LT:   c_res = !c_eq && !c_gt;
         default: c_res = 1'b0;
      endcase
   end

   assign rn_t = {rn_ff, nm_ff[PW-1]};
   assign rd_t = {rd_ff, dm_ff[PW-1]};
   assign ovf  = (dm_ff > (LIM - 1'b1)) || (nm_ff > (neg_ff ? LIM : (LIM - 1'b1)));

   always_ff @(posedge clock) begin
      unique case (ctrl.cmd)
         CMD_LOAD: begin
            func_ff   <= req_func;
            unused_ff <= (req_func == FN_NONE);
            zden_ff   <= (req_a_den == '0) || (req_b_den == '0) ||
                         ((req_func == FN_DIV) && (req_b_num == '0));
            sa_ff     <= (req_a_num[WIDTH-1] ^ req_a_den[WIDTH-1]) && (req_a_num != '0);
            sb_ff     <= (req_b_num[WIDTH-1] ^ req_b_den[WIDTH-1]) && (req_b_num != '0);
            am_ff     <= mag_of(req_a_num);
            adm_ff    <= mag_of(req_a_den);
            bm_ff     <= mag_of(req_b_num);
            bdm_ff    <= mag_of(req_b_den);
         end
         CMD_MUL: begin
            unique case (ctrl.mul_sel)
               MSEL_X:  x_ff <= prod;
               MSEL_Y:  y_ff <= prod;
               default: d_ff <= prod;
            endcase
         end
         CMD_COMBINE: begin
            cmp_ff <= c_res;
            k_ff   <= '0;
            if (is_mul || is_div) begin
               nm_ff  <= x_ff;
               dm_ff  <= y_ff;
               u_ff   <= x_ff;
               v_ff   <= y_ff;
               neg_ff <= sa_ff ^ sb_ff;
            end else begin
               nm_ff  <= sum_mag;
               dm_ff  <= d_ff;
               u_ff   <= sum_mag;
               v_ff   <= d_ff;
               neg_ff <= sum_neg;
            end
         end
         CMD_GCD: begin
            // binary gcd, one step per cycle
            priority if (!u_ff[0] && !v_ff[0]) begin
               u_ff <= u_ff >> 1;
               v_ff <= v_ff >> 1;
               k_ff <= k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_ff <= u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_ff <= v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_ff <= (u_ff - v_ff) >> 1;
            end else begin
               v_ff <= (v_ff - u_ff) >> 1;
            end
         end
         CMD_DIV_INIT: begin
            g_ff  <= u_ff << k_ff;
            rn_ff <= '0;
            rd_ff <= '0;
         end
         CMD_DIV: begin
            // both quotients shift into the dividend registers
            if (rn_t >= {1'b0, g_ff}) begin
               rn_ff <= PW'(rn_t - {1'b0, g_ff});
               nm_ff <= {nm_ff[PW-2:0], 1'b1};
            end else begin
               rn_ff <= rn_t[PW-1:0];
               nm_ff <= {nm_ff[PW-2:0], 1'b0};
            end
            if (rd_t >= {1'b0, g_ff}) begin
               rd_ff <= PW'(rd_t - {1'b0, g_ff});
               dm_ff <= {dm_ff[PW-2:0], 1'b1};
            end else begin
               rd_ff <= rd_t[PW-1:0];
               dm_ff <= {dm_ff[PW-2:0], 1'b0};
            end
         end
         CMD_PUT: begin
            priority if (unused_ff) begin
               num_out_ff <= '0;
               den_out_ff <= (WIDTH-1)'(1);
               cmpo_ff    <= 1'b0;
               st_ff      <= ST_OK;
            end else if (zden_ff) begin
               num_out_ff <= '0;
               den_out_ff <= '0;
               cmpo_ff    <= 1'b0;
               st_ff      <= ST_ZDEN;
            end else if (is_cmp) begin
               num_out_ff <= '0;
               den_out_ff <= (WIDTH-1)'(1);
               cmpo_ff    <= cmp_ff;
               st_ff      <= ST_OK;
            end else if (nm_ff == '0) begin
               num_out_ff <= '0;
               den_out_ff <= (WIDTH-1)'(1);
               cmpo_ff    <= 1'b0;
               st_ff      <= ST_OK;
            end else if (ovf) begin
               num_out_ff <= '0;
               den_out_ff <= '0;
               cmpo_ff    <= 1'b0;
               st_ff      <= ST_OVF;
            end else begin
               num_out_ff <= neg_ff ? (~nm_ff[WIDTH-1:0] + 1'b1) : nm_ff[WIDTH-1:0];
               den_out_ff <= dm_ff[WIDTH-2:0];
               cmpo_ff    <= 1'b0;
               st_ff      <= ST_OK;
            end
         end
         default: ;
      endcase
   end

   assign stat.skip      = unused_ff || zden_ff;
   assign stat.early_out = is_cmp || (nm_ff == '0);
   assign stat.gcd_done  = (u_ff == v_ff);

   assign rsp_res_num  = num_out_ff;
   assign rsp_res_den  = den_out_ff;
   assign rsp_cmp_true = cmpo_ff;
   assign rsp_status   = st_ff;

endmodule

/* bench/rational_fraction_alu_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_fraction_alu_tb
// Drives signed fraction pairs through every operation, predicts the reduced
// result or comparison flag at 130 bits, and checks each response strobe.
// ----------------------------------------------------------------------------
module rational_fraction_alu_tb import rfa_pkg::*;;

   typedef struct {
      logic signed [WIDTH-1:0] num;
      logic [WIDTH-2:0]        den;
      logic                    cmp;
      logic [1:0]              st;
   } answer_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [2:0]              req_func = FN_ADD;
   logic signed [WIDTH-1:0] req_a_num = '0;
   logic signed [WIDTH-1:0] req_a_den = '0;
   logic signed [WIDTH-1:0] req_b_num = '0;
   logic signed [WIDTH-1:0] req_b_den = '0;
   logic                    rsp_valid;
   logic signed [WIDTH-1:0] rsp_res_num;
   logic [WIDTH-2:0]        rsp_res_den;
   logic                    rsp_cmp_true;
   logic [1:0]              rsp_status;

   answer_type answers[$];
   int      errors = 0;
   int      burst_left = 0;

   rational_fraction_alu dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [129:0] gcd128(logic [129:0] x, logic [129:0] y);
      logic [129:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // signed math at 130 bits is exact for the 64-bit cross products
   function automatic answer_type reduce_fraction(logic [2:0] fn, logic signed [31:0] an,
         logic signed [31:0] ad, logic signed [31:0] bn, logic signed [31:0] bd);
      answer_type r;
      logic signed [129:0] xn, xd, yn, yd, n, d, p, q, g;
      r = '{num: '0, den: '0, cmp: 1'b0, st: ST_OK};
      if (fn == FN_NONE) begin
         r.den = (WIDTH-1)'(1);
         return r;
      end
      if (ad == 0 || bd == 0 || (fn == FN_DIV && bn == 0)) begin
         r.st = ST_ZDEN;
         return r;
      end
      xn = an; xd = ad; yn = bn; yd = bd;
      if (xd < 0) begin xn = -xn; xd = -xd; end
      if (yd < 0) begin yn = -yn; yd = -yd; end
      p = xn * yd;
      q = yn * xd;
      if (fn >= FN_EQ) begin
         r.den = (WIDTH-1)'(1);
         r.cmp = (fn == FN_EQ) ? (p == q) : (fn == FN_GT) ? (p > q) : (p < q);
         return r;
      end
      case (fn)
         FN_ADD: begin n = p + q; d = xd * yd; end
         FN_SUB: begin n = p - q; d = xd * yd; end
         FN_MUL: begin n = xn * yn; d = xd * yd; end
         default: begin n = p; d = xd * yn; end
      endcase
      if (d < 0) begin n = -n; d = -d; end
      if (n == 0) begin
         r.den = (WIDTH-1)'(1);
         return r;
      end
      g = gcd128(n < 0 ? -n : n, d);
      n = n / g;
      d = d / g;
      if (d > 130'sd2147483647 || n > 130'sd2147483647 || n < -130'sd2147483648) begin
         r.st = ST_OVF;
         return r;
      end
      r.num = n[31:0];
      r.den = d[30:0];
      return r;
   endfunction

   // start stays high after acceptance until a gap or a drain lowers it
   task automatic send_fraction(logic [2:0] fn, logic [31:0] an, logic [31:0] ad,
         logic [31:0] bn, logic [31:0] bd);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
      end
      burst_left--;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= fn;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      answers.push_back(reduce_fraction(fn, an, ad, bn, bd));
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20) - 10;
         1: return $urandom_range(0, 2000) - 1000;
         2: return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                   + $urandom_range(0, 4) - 2;
         3: return $urandom_range(0, 1 << 16);
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] big, min_v;
      big = 32'h7FFF_FFFF;
      min_v = 32'h8000_0000;
      for (int f = 0; f < 8; f++) send_fraction(f[2:0], 3, 4, -5, 6);
      send_fraction(FN_ADD, 1, 0, 1, 2);
      send_fraction(FN_EQ, 1, 2, 1, 0);
      send_fraction(FN_DIV, 1, 2, 0, 5);
      send_fraction(FN_SUB, 1, 2, 1, 2);
      send_fraction(FN_MUL, big, 1, big, 1);
      send_fraction(FN_MUL, min_v, 1, 1, 1);
      send_fraction(FN_DIV, min_v, 1, -1, 1);
      send_fraction(FN_ADD, 1, big, 1, min_v);
      send_fraction(FN_LT, min_v, min_v, big, big);
      send_fraction(FN_GT, -1, -3, 1, 3);
      send_fraction(FN_EQ, 2, -4, -1, 2);
      send_fraction(FN_DIV, big, min_v, min_v, big);
      send_fraction(FN_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 7);
      drain_results();
   endtask

   task automatic test_random(int count);
      logic [31:0] an, ad, bn, bd;
      for (int i = 0; i < count; i++) begin
         an = pick_value(); ad = pick_value(); bn = pick_value(); bd = pick_value();
         if ($urandom_range(0, 30) == 0) ad = 0;
         if ($urandom_range(0, 30) == 0) bn = 0;
         if ($urandom_range(0, 5) == 0) bd = ad;
         send_fraction(3'($urandom_range(0, 7)), an, ad, bn, bd);
         // wait for an empty pipeline once in a while
         if (i % 200 == 100) drain_results();
      end
   endtask

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         if (answers.size() == 0) begin
            $display("%0t: unexpected transaction num %0d den %0d", $realtime,
                     rsp_res_num, rsp_res_den);
            errors++;
         end else begin
            e = answers.pop_front();
            if (rsp_res_num !== e.num || rsp_res_den !== e.den ||
                rsp_cmp_true !== e.cmp || rsp_status !== e.st) begin
               $display("%0t: expected %0d/%0d cmp %0d st %0d, got %0d/%0d cmp %0d st %0d",
                        $realtime, e.num, e.den, e.cmp, e.st, rsp_res_num, rsp_res_den,
                        rsp_cmp_true, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(750);
      drain_results();
      if (errors == 0 && answers.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #10000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
